@@ design/ordered_list_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Ordered list engine: assertion macros
// Shared property shorthands for the checker that is bound to the top level.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_LIST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define OLIST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define OLIST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/olist_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered list engine package
// Opcodes, status codes, cell commands and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package olist_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int OPCODE_W        = 4;
  localparam int PLACE_W         = 8;
  localparam int STATUS_W        = 3;

  localparam logic [OPCODE_W-1:0] OP_INS_AFTER  = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_DEL_VAL    = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_DEL_POS    = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_READ_FWD   = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_READ_REV   = 4'd8;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // Command broadcast to every cell of the ring, all in the same cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRAP,
    CELL_ROTR
  } cell_op_e;

endpackage

`default_nettype wire

@@ design/ordered_list_engine_unit.sv @@
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded deque of signed values held in a ring of cells with a sequencer.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every result is shown
// for exactly one cycle with result_valid_o and the receiver cannot stall it,
// so it must take each result as it comes. Inserts, pushes, pops and delete
// by position finish with at most one cell update, and a new item is taken
// only once busy has fallen. Delete by value and forward readout step the
// ring once per entry, and a forward readout gives one entry per cycle.
// Reverse readout turns the whole ring of CAPACITY cells once, with its
// entries in the last length of those steps.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_engine_unit #(
  parameter int CAPACITY    = olist_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   start,
  output logic                                  busy,
  input  wire  [olist_pkg::OPCODE_W-1:0]        opcode_i,
  input  wire  signed [VALUE_WIDTH-1:0]         item_value_i,
  input  wire  signed [olist_pkg::PLACE_W-1:0]  place_i,
  output logic                                  result_valid_o,
  output logic [olist_pkg::STATUS_W-1:0]        status_o,
  output logic signed [VALUE_WIDTH-1:0]         read_value_o,
  output logic [$clog2(CAPACITY+1)-1:0]         entry_count_o,
  output logic                                  last_o
);

  localparam int KW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY+1);
  localparam int CW = (LW > olist_pkg::PLACE_W) ? LW : olist_pkg::PLACE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0]                          state_d, state_q;
  logic [olist_pkg::OPCODE_W-1:0]      op_q;
  logic [VALUE_WIDTH-1:0]              val_q;
  logic [olist_pkg::PLACE_W-1:0]       place_q;
  logic [LW-1:0]                       len_d, len_q;
  logic [LW-1:0]                       rem_d, rem_q;
  logic                                found_d, found_q;
  logic                                valid_d, valid_q;
  logic [olist_pkg::STATUS_W-1:0]      status_d, status_q;
  logic [VALUE_WIDTH-1:0]              rdval_d, rdval_q;
  logic                                last_d, last_q;

  olist_pkg::cell_op_e                 cell_op;
  logic [KW-1:0]                       cell_k;
  logic [VALUE_WIDTH-1:0]              cell_b;
  logic [VALUE_WIDTH-1:0]              cell_val [CAPACITY];
  logic [VALUE_WIDTH-1:0]              head, tail;

  logic                                accept;
  logic                                pl_neg;
  logic [CW-1:0]                       pl_mag;
  logic [CW-1:0]                       len_ext;
  logic                                is_full;
  logic                                is_empty;
  logic                                match;

  // --------------------------------------------------------------------------
  // Cell ring
  // --------------------------------------------------------------------------
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int Left  = (g + CAPACITY - 1) % CAPACITY;
    localparam int Right = (g + 1) % CAPACITY;
    olist_cell #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX         (g)
    ) u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op),
      .k_i     (cell_k),
      .bcast_i (cell_b),
      .left_i  (cell_val[Left]),
      .right_i (cell_val[Right]),
      .val_o   (cell_val[g])
    );
  end

  assign head = cell_val[0];
  assign tail = cell_val[CAPACITY-1];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign accept   = start && (state_q == S_IDLE);
  assign pl_neg   = place_q[olist_pkg::PLACE_W-1];
  assign pl_mag   = CW'(place_q[olist_pkg::PLACE_W-2:0]);
  assign len_ext  = CW'(len_q);
  assign is_full  = (len_q == LW'(CAPACITY));
  assign is_empty = (len_q == '0);
  assign match    = !found_q && (head == val_q);

  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    rem_d    = rem_q;
    found_d  = found_q;
    valid_d  = 1'b0;
    status_d = status_q;
    rdval_d  = rdval_q;
    last_d   = last_q;
    cell_op  = olist_pkg::CELL_HOLD;
    cell_k   = '0;
    cell_b   = val_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        state_d  = S_IDLE;
        valid_d  = 1'b1;
        status_d = olist_pkg::ST_OK;
        rdval_d  = '0;
        last_d   = 1'b1;
        case (op_q)
          olist_pkg::OP_INS_AFTER: begin
            if (pl_neg) begin
              status_d = olist_pkg::ST_BADPOS;
            end else if (is_full) begin
              status_d = olist_pkg::ST_FULL;
            end else if (is_empty) begin
              cell_op = olist_pkg::CELL_INSERT;
              cell_k  = '0;
              len_d   = len_q + LW'(1);
            end else if (pl_mag >= len_ext) begin
              status_d = olist_pkg::ST_BADPOS;
            end else begin
              cell_op = olist_pkg::CELL_INSERT;
              cell_k  = KW'(pl_mag + CW'(1));
              len_d   = len_q + LW'(1);
            end
          end
          olist_pkg::OP_DEL_VAL: begin
            if (is_empty) begin
              status_d = olist_pkg::ST_EMPTY;
            end else begin
              state_d = S_WALK;
              valid_d = 1'b0;
              rem_d   = len_q;
              found_d = 1'b0;
            end
          end
          olist_pkg::OP_DEL_POS: begin
            if (is_empty) begin
              status_d = olist_pkg::ST_EMPTY;
            end else if (pl_neg || (pl_mag == '0) || (pl_mag > len_ext)) begin
              status_d = olist_pkg::ST_BADPOS;
            end else begin
              cell_op = olist_pkg::CELL_REMOVE;
              cell_k  = KW'(pl_mag - CW'(1));
              len_d   = len_q - LW'(1);
            end
          end
          olist_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
              status_d = olist_pkg::ST_FULL;
            end else begin
              cell_op = olist_pkg::CELL_INSERT;
              cell_k  = KW'(len_q);
              len_d   = len_q + LW'(1);
            end
          end
          olist_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
              status_d = olist_pkg::ST_FULL;
            end else begin
              cell_op = olist_pkg::CELL_INSERT;
              cell_k  = '0;
              len_d   = len_q + LW'(1);
            end
          end
          olist_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
              status_d = olist_pkg::ST_EMPTY;
            end else begin
              cell_op = olist_pkg::CELL_REMOVE;
              cell_k  = '0;
              len_d   = len_q - LW'(1);
            end
          end
          olist_pkg::OP_POP_BACK: begin
            if (is_empty) begin
              status_d = olist_pkg::ST_EMPTY;
            end else begin
              len_d = len_q - LW'(1);
            end
          end
          olist_pkg::OP_READ_FWD: begin
            if (is_empty) begin
              status_d = olist_pkg::ST_EMPTY;
            end else begin
              state_d = S_WALK;
              valid_d = 1'b0;
              rem_d   = len_q;
            end
          end
          olist_pkg::OP_READ_REV: begin
            if (is_empty) begin
              status_d = olist_pkg::ST_EMPTY;
            end else begin
              state_d = S_WALK;
              valid_d = 1'b0;
              rem_d   = LW'(CAPACITY);
            end
          end
          default: begin
            status_d = olist_pkg::ST_OK;
          end
        endcase
      end

      S_WALK: begin
        rem_d = rem_q - LW'(1);
        if (rem_q == LW'(1)) begin
          state_d = S_IDLE;
        end
        case (op_q)
          // Each step takes the head: it is either dropped (first match) or
          // moved to the tail, so one pass keeps the order of the survivors.
          olist_pkg::OP_DEL_VAL: begin
            if (match) begin
              cell_op = olist_pkg::CELL_REMOVE;
              cell_k  = '0;
              len_d   = len_q - LW'(1);
              found_d = 1'b1;
            end else begin
              cell_op = olist_pkg::CELL_WRAP;
              cell_k  = KW'(len_q - LW'(1));
              cell_b  = head;
            end
            if (rem_q == LW'(1)) begin
              valid_d  = 1'b1;
              last_d   = 1'b1;
              rdval_d  = '0;
              status_d = (found_q || match) ? olist_pkg::ST_OK : olist_pkg::ST_NOTFOUND;
            end
          end
          olist_pkg::OP_READ_FWD: begin
            cell_op  = olist_pkg::CELL_WRAP;
            cell_k   = KW'(len_q - LW'(1));
            cell_b   = head;
            valid_d  = 1'b1;
            status_d = olist_pkg::ST_OK;
            rdval_d  = head;
            last_d   = (rem_q == LW'(1));
          end
          olist_pkg::OP_READ_REV: begin
            // The whole ring turns once; the tail cell shows the entries from
            // the back once the list has been carried up against it.
            cell_op = olist_pkg::CELL_ROTR;
            if (rem_q <= len_q) begin
              valid_d  = 1'b1;
              status_d = olist_pkg::ST_OK;
              rdval_d  = tail;
              last_d   = (rem_q == LW'(1));
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      rem_q   <= '0;
      found_q <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
      found_q <= found_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      val_q   <= $unsigned(item_value_i);
      place_q <= $unsigned(place_i);
    end
    status_q <= status_d;
    rdval_q  <= rdval_d;
    last_q   <= last_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign read_value_o   = $signed(rdval_q);
  assign entry_count_o  = len_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

@@ design/olist_cell.sv @@
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry and moves it to or from its neighbours on command.
// ----------------------------------------------------------------------------
`default_nettype none

module olist_cell #(
  parameter int CAPACITY    = olist_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF,
  parameter int IDX         = 0
) (
  input  wire                          clk_i,
  input  olist_pkg::cell_op_e          op_i,
  input  wire [$clog2(CAPACITY)-1:0]   k_i,
  input  wire [VALUE_WIDTH-1:0]        bcast_i,
  input  wire [VALUE_WIDTH-1:0]        left_i,
  input  wire [VALUE_WIDTH-1:0]        right_i,
  output logic [VALUE_WIDTH-1:0]       val_o
);

  localparam int KW = $clog2(CAPACITY);
  localparam logic [KW-1:0] MyIdx = KW'(IDX);

  logic [VALUE_WIDTH-1:0] val_d, val_q;

  always_comb begin
    val_d = val_q;
    case (op_i)
      olist_pkg::CELL_HOLD: val_d = val_q;
      olist_pkg::CELL_INSERT: begin
        if (MyIdx > k_i) begin
          val_d = left_i;
        end else if (MyIdx == k_i) begin
          val_d = bcast_i;
        end
      end
      olist_pkg::CELL_REMOVE: begin
        if (MyIdx >= k_i) begin
          val_d = right_i;
        end
      end
      // Rotation inside the live region: the cell at the tail takes the head.
      olist_pkg::CELL_WRAP: begin
        if (MyIdx < k_i) begin
          val_d = right_i;
        end else if (MyIdx == k_i) begin
          val_d = bcast_i;
        end
      end
      olist_pkg::CELL_ROTR: val_d = left_i;
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

@@ design/olist_checker.sv @@
// ----------------------------------------------------------------------------
// Ordered list engine checker
// Port-level properties of the engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ordered_list_engine_unit_defines.svh"

module olist_checker #(
  parameter int CAPACITY    = olist_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = olist_pkg::VALUE_WIDTH_DEF
) (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  start,
  input wire                                  busy,
  input wire                                  result_valid_o,
  input wire [olist_pkg::STATUS_W-1:0]        status_o,
  input wire signed [VALUE_WIDTH-1:0]         read_value_o,
  input wire [$clog2(CAPACITY+1)-1:0]         entry_count_o,
  input wire                                  last_o
);

  // An accepted item keeps the engine busy for at least the following cycle.
  `OLIST_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy && !result_valid_o, "item accepted but engine not busy next cycle")

  // The final result of an item frees the engine in the same cycle.
  `OLIST_ASSERT_IMP(a_last_frees, clk_i, rst_ni, result_valid_o && last_o, !busy, "final result shown while still busy")

  // More results are due, so the engine must stay busy.
  `OLIST_ASSERT_IMP(a_more_busy, clk_i, rst_ni, result_valid_o && !last_o, busy, "non-final result shown while idle")

  // Error results never carry an entry value.
  `OLIST_ASSERT_IMP(a_err_zero, clk_i, rst_ni, result_valid_o && (status_o != olist_pkg::ST_OK), read_value_o == '0, "error result with non-zero value")

  // The count does not move in the middle of a readout.
  `OLIST_ASSERT_NXT(a_count_hold, clk_i, rst_ni, result_valid_o && !last_o, $stable(entry_count_o), "entry count changed during readout")

endmodule

bind ordered_list_engine_unit olist_checker #(
  .CAPACITY    (CAPACITY),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_olist_checker (.*);

`default_nettype wire
